[rtl/rgbenc_pkg.sv]
`timescale 1ns / 1ps

package rgbenc_pkg;

  localparam int unsigned ColourW    = 24;
  localparam int unsigned TicksW     = 8;
  localparam int unsigned LedCntW    = 7;
  localparam int unsigned BitCntW    = 5;
  localparam int unsigned ApbAddrW   = 3;
  localparam int unsigned ApbDataW   = 32;

  localparam logic [LedCntW-1:0] MaxStrip     = 7'd60;
  localparam logic [BitCntW-1:0] BitsPerLed   = 5'd24;
  localparam logic [TicksW-1:0]  ZeroTicksRst = 8'd12;
  localparam logic [TicksW-1:0]  OneTicksRst  = 8'd24;

  // register index, taken from paddr[2]
  localparam logic RegZeroTicks = 1'b0;
  localparam logic RegOneTicks  = 1'b1;

  typedef struct packed {
    logic load;
    logic emit_bit;
    logic emit_flag;
    logic emit_pad;
  } rgbenc_cmd_t;

  typedef struct packed {
    logic full;
    logic last;
    logic bits_done;
    logic out_free;
  } rgbenc_stat_t;

endpackage

[rtl/rgbenc_ctrl.sv]
`timescale 1ns / 1ps

module rgbenc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rgbenc_pkg::rgbenc_stat_t stat_i,
  output rgbenc_pkg::rgbenc_cmd_t  cmd_o
);
  import rgbenc_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StBits = 2'd1;
  localparam logic [1:0] StFlag = 2'd2;
  localparam logic [1:0] StPad  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.full ? StFlag : StBits;
        end
      end
      StBits: begin
        if (stat_i.out_free) begin
          cmd_o.emit_bit = 1'b1;
          if (stat_i.bits_done) begin
            state_d = stat_i.last ? StPad : StIdle;
          end
        end
      end
      StFlag: begin
        if (stat_i.out_free) begin
          cmd_o.emit_flag = 1'b1;
          state_d = stat_i.last ? StPad : StIdle;
        end
      end
      StPad: begin
        if (stat_i.out_free) begin
          cmd_o.emit_pad = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/rgbenc_dp.sv]
`timescale 1ns / 1ps

module rgbenc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rgbenc_pkg::ColourW-1:0]        colour_i,
  input  logic                                  last_led_i,
  input  logic [rgbenc_pkg::TicksW-1:0]         zero_ticks_i,
  input  logic [rgbenc_pkg::TicksW-1:0]         one_ticks_i,
  input  rgbenc_pkg::rgbenc_cmd_t               cmd_i,
  output rgbenc_pkg::rgbenc_stat_t              stat_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rgbenc_pkg::TicksW-1:0]         high_ticks_o,
  output logic                                  data_bit_o,
  output logic                                  pad_bit_o,
  output logic                                  too_many_o,
  output logic                                  run_end_o
);
  import rgbenc_pkg::*;

  logic [ColourW-1:0] shift_q, shift_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  logic [LedCntW-1:0] leds_q, leds_d;
  logic               last_q, last_d;
  logic               out_valid_q, out_valid_d;
  logic [TicksW-1:0]  ticks_q, ticks_d;
  logic               bit_q, bit_d;
  logic               pad_q, pad_d;
  logic               flag_q, flag_d;
  logic               end_q, end_d;
  logic               full;
  logic               emit;

  assign full = (leds_q >= MaxStrip);
  assign emit = cmd_i.emit_bit | cmd_i.emit_flag | cmd_i.emit_pad;

  assign stat_o.full      = full;
  assign stat_o.last      = last_q;
  assign stat_o.bits_done = (bits_q == BitCntW'(1));
  assign stat_o.out_free  = ~out_valid_q | out_ready_i;

  always_comb begin
    shift_d     = shift_q;
    bits_d      = bits_q;
    leds_d      = leds_q;
    last_d      = last_q;
    ticks_d     = ticks_q;
    bit_d       = bit_q;
    pad_d       = pad_q;
    flag_d      = flag_q;
    end_d       = end_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (cmd_i.load) begin
      // wire order is green, red, blue
      shift_d = {colour_i[15:8], colour_i[23:16], colour_i[7:0]};
      bits_d  = BitsPerLed;
      last_d  = last_led_i;
      if (!full) begin
        leds_d = leds_q + LedCntW'(1);
      end
    end

    if (cmd_i.emit_bit) begin
      ticks_d = shift_q[ColourW-1] ? one_ticks_i : zero_ticks_i;
      bit_d   = shift_q[ColourW-1];
      pad_d   = 1'b0;
      flag_d  = 1'b0;
      end_d   = (bits_q == BitCntW'(1)) & ~last_q;
      shift_d = {shift_q[ColourW-2:0], 1'b0};
      bits_d  = bits_q - BitCntW'(1);
    end

    if (cmd_i.emit_flag) begin
      ticks_d = '0;
      bit_d   = 1'b0;
      pad_d   = 1'b0;
      flag_d  = 1'b1;
      end_d   = ~last_q;
    end

    if (cmd_i.emit_pad) begin
      ticks_d = zero_ticks_i;
      bit_d   = 1'b0;
      pad_d   = 1'b1;
      flag_d  = 1'b0;
      end_d   = 1'b1;
      leds_d  = '0;
    end

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bits_q      <= '0;
      leds_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      leds_q      <= leds_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ticks_q <= ticks_d;
    bit_q   <= bit_d;
    pad_q   <= pad_d;
    flag_q  <= flag_d;
    end_q   <= end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign high_ticks_o = ticks_q;
  assign data_bit_o   = bit_q;
  assign pad_bit_o    = pad_q;
  assign too_many_o   = flag_q;
  assign run_end_o    = end_q;

endmodule

[rtl/rgb_led_bit_timing_encoder_top.sv]
`timescale 1ns / 1ps

// Serial RGB LED bit encoder. Each request carries one LED colour as 0xRRGGBB
// and is sent out as 24 pulse codes in green, red, blue order, MSB first,
// each giving the high time in ticks for a 0 or a 1 bit (APB registers at
// 0x0 and 0x4). A request flagged last_led is followed by a zero-bit pad
// code and restarts the frame count. Requests beyond 60 LEDs in a frame are
// dropped and answered by one result with too_many set. An LED request is
// loaded, then sends one code per cycle from the shift register, while the
// output is free, into the output register, then the pad code if flagged;
// a dropped one sends its too_many result and then the pad if flagged. The
// next request is taken once the last code of the current one is registered.

module rgb_led_bit_timing_encoder_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [rgbenc_pkg::ColourW-1:0]        colour_i,
  input  logic                                  last_led_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [rgbenc_pkg::TicksW-1:0]         high_ticks_o,
  output logic                                  data_bit_o,
  output logic                                  pad_bit_o,
  output logic                                  too_many_o,
  output logic                                  run_end_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rgbenc_pkg::ApbAddrW-1:0]       paddr,
  input  logic [rgbenc_pkg::ApbDataW-1:0]       pwdata,
  output logic [rgbenc_pkg::ApbDataW-1:0]       prdata,
  output logic                                  pready
);
  import rgbenc_pkg::*;

  logic [TicksW-1:0] zero_ticks_q, zero_ticks_d;
  logic [TicksW-1:0] one_ticks_q, one_ticks_d;
  logic              wr_en;
  rgbenc_cmd_t       cmd;
  rgbenc_stat_t      stat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    zero_ticks_d = zero_ticks_q;
    one_ticks_d  = one_ticks_q;
    if (wr_en) begin
      case (paddr[2])
        RegZeroTicks: zero_ticks_d = pwdata[TicksW-1:0];
        RegOneTicks:  one_ticks_d  = pwdata[TicksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegZeroTicks: prdata = ApbDataW'(zero_ticks_q);
      RegOneTicks:  prdata = ApbDataW'(one_ticks_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_ticks_q <= ZeroTicksRst;
      one_ticks_q  <= OneTicksRst;
    end else begin
      zero_ticks_q <= zero_ticks_d;
      one_ticks_q  <= one_ticks_d;
    end
  end

  rgbenc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rgbenc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .colour_i     (colour_i),
    .last_led_i   (last_led_i),
    .zero_ticks_i (zero_ticks_q),
    .one_ticks_i  (one_ticks_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .high_ticks_o (high_ticks_o),
    .data_bit_o   (data_bit_o),
    .pad_bit_o    (pad_bit_o),
    .too_many_o   (too_many_o),
    .run_end_o    (run_end_o)
  );

endmodule
